[design/assert_macros.svh]
// Assertion macros shared by the DMX transmitter RTL.
// Expects clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// pre holds -> post holds in the same cycle
`define DMX_ASSERT_IMPLIES(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// pre holds -> post holds in the next cycle
`define DMX_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[design/dmx_pkg.sv]
// Shared types and constants of the DMX512 frame transmitter.
// No dependencies.
package dmx_pkg;

    typedef enum logic [1:0] {
        OP_TICK        = 2'd0,
        OP_WRITE       = 2'd1,
        OP_SET_HIGHEST = 2'd2,
        OP_NOP         = 2'd3
    } op_t;

    localparam logic CFG_BURST_PERIOD = 1'b0;
    localparam logic CFG_BURST_BUDGET = 1'b1;

    localparam int NUM_CHANNELS_DEF = 512;
    localparam int BREAK_BITS_DEF   = 22;
    localparam int SLOT_BITS        = 11;
    localparam int MAB_BITS         = 2;

    localparam int CH_W  = 10;
    localparam int VAL_W = 8;
    localparam int CFG_W = 16;

    localparam logic [CFG_W-1:0] PERIOD_RST  = 16'd510;
    localparam logic [CFG_W-1:0] BUDGET_RST  = 16'd127;
    localparam logic [CH_W-1:0]  HIGHEST_RST = 10'd16;

    typedef struct packed {
        logic            line_level;
        logic            slot_active;
        logic [CH_W-1:0] slot_number;
    } result_t;

    typedef struct packed {
        logic load_pending;
        logic in_slot;
    } core_status_t;

endpackage

[design/dmx_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dmx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/dmx_clr.sv]
// Post-reset clearing sweep over the channel store, one entry per cycle.
// No dependencies.
module dmx_clr #(
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    output logic          busy,
    output logic [AW-1:0] addr
);

    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic          busy_reg, busy_next;
    logic [AW-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (busy_reg)
        begin
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign busy = busy_reg;
    assign addr = cnt_reg;

endmodule

[design/dmx_core.sv]
// Frame sequencer of the DMX transmitter: burst timing, slot state and line level.
// Depends on dmx_pkg; drives the channel store ports of dmx_ram.
module dmx_core #(
    parameter int NUM_CHANNELS = dmx_pkg::NUM_CHANNELS_DEF,
    parameter int BREAK_BITS   = dmx_pkg::BREAK_BITS_DEF,
    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [1:0]                  operation,
    input  logic [dmx_pkg::CH_W-1:0]    channel,
    input  logic [dmx_pkg::VAL_W-1:0]   value,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [dmx_pkg::CFG_W-1:0]   cfg_data,
    output logic                        st_we,
    output logic [AW-1:0]               st_waddr,
    output logic [dmx_pkg::VAL_W-1:0]   st_wdata,
    output logic [AW-1:0]               st_raddr,
    input  logic [dmx_pkg::VAL_W-1:0]   st_rdata,
    output dmx_pkg::result_t            result,
    output dmx_pkg::core_status_t       status
);

    localparam int BIT_W = $clog2(BREAK_BITS + dmx_pkg::MAB_BITS + dmx_pkg::SLOT_BITS + 1);
    localparam int CH_W  = dmx_pkg::CH_W;
    localparam int CW    = dmx_pkg::CFG_W;

    localparam logic [CH_W-1:0]  NCH       = CH_W'(NUM_CHANNELS);
    localparam logic [BIT_W-1:0] BRK       = BIT_W'(BREAK_BITS);
    localparam logic [BIT_W-1:0] BRK_MAB   = BIT_W'(BREAK_BITS + dmx_pkg::MAB_BITS);
    localparam logic [BIT_W-1:0] HEAD_LEN  =
        BIT_W'(BREAK_BITS + dmx_pkg::MAB_BITS + dmx_pkg::SLOT_BITS);
    localparam logic [BIT_W-1:0] SLOT_LEN  = BIT_W'(dmx_pkg::SLOT_BITS);
    localparam logic [CW-1:0]    HEAD_COST =
        CW'(BREAK_BITS + dmx_pkg::MAB_BITS + dmx_pkg::SLOT_BITS);
    localparam logic [CW-1:0]    SLOT_COST = CW'(dmx_pkg::SLOT_BITS);

    // Level of bit pos within the current slot.
    function automatic logic level_of(input logic act, input logic head,
                                      input logic [BIT_W-1:0] pos,
                                      input logic [dmx_pkg::VAL_W-1:0] b);
        logic [BIT_W-1:0] p;
        logic [BIT_W-1:0] pm1;
        logic             lv;
        p   = head ? (pos - BRK_MAB) : pos;
        pm1 = p - BIT_W'(1);
        if (!act)
            lv = 1'b1;
        else if (head && pos < BRK)
            lv = 1'b0;
        else if (head && pos < BRK_MAB)
            lv = 1'b1;
        else if (p == '0)
            lv = 1'b0;
        else if (p <= BIT_W'(8))
            lv = b[pm1[2:0]];
        else
            lv = 1'b1;
        return lv;
    endfunction

    dmx_pkg::op_t op;

    logic [CW-1:0]    period_reg, period_next;
    logic [CW-1:0]    budget_reg, budget_next;
    logic [CH_W-1:0]  highest_reg, highest_next;
    logic             running_reg, running_next;
    logic [CH_W-1:0]  slot_reg, slot_next;
    logic [BIT_W-1:0] bitpos_reg, bitpos_next;
    logic             in_slot_reg, in_slot_next;
    logic [7:0]       shift_reg, shift_next;
    logic [CW-1:0]    left_reg, left_next;
    logic [CW-1:0]    pcount_reg, pcount_next;
    logic             over_reg, over_next;
    logic             pending_reg, pending_next;

    logic [CW-1:0]    period_eff, budget_sat, pc_inc, left_open, cost;
    logic             wrap, opening, over_open, is_tick, want, fits, start;
    logic             head, emit_in_slot, level;
    logic [BIT_W-1:0] emit_pos, pos_inc, slot_len;
    logic [CH_W:0]    slot_inc;
    logic [7:0]       shift_eff;
    logic             store_zero;

    assign op         = dmx_pkg::op_t'(operation);
    assign shift_eff  = pending_reg ? st_rdata : shift_reg;
    assign head       = (slot_reg == '0);
    assign period_eff = (period_reg == '0) ? CW'(1) : period_reg;
    assign budget_sat = (budget_reg < period_eff) ? budget_reg : period_eff;
    assign pc_inc     = pcount_reg + CW'(1);
    assign wrap       = (pc_inc >= period_eff);
    assign opening    = wrap && running_reg;
    assign left_open  = opening ? budget_sat : left_reg;
    assign over_open  = opening ? 1'b0 : over_reg;
    assign cost       = head ? HEAD_COST : SLOT_COST;
    assign is_tick    = (op == dmx_pkg::OP_TICK);
    assign want       = !in_slot_reg && running_reg && !over_open;
    assign fits       = (left_open >= cost);
    assign start      = is_tick && want && fits;
    assign store_zero = head || (slot_reg > NCH);

    assign emit_in_slot = in_slot_reg || start;
    assign emit_pos     = start ? '0 : bitpos_reg;
    assign pos_inc      = emit_pos + BIT_W'(1);
    assign slot_len     = head ? HEAD_LEN : SLOT_LEN;
    assign slot_inc     = {1'b0, slot_reg} + (CH_W+1)'(1);
    assign level        = level_of(emit_in_slot, head, emit_pos, shift_eff);

    assign result.line_level  = level;
    assign result.slot_active = emit_in_slot;
    assign result.slot_number = slot_reg;

    // Channel store read for the slot being started; data lands in the next cycle.
    assign st_raddr = AW'(slot_reg - CH_W'(1));
    assign st_waddr = AW'(channel - CH_W'(1));
    assign st_wdata = value;

    always_comb
    begin
        period_next  = period_reg;
        budget_next  = budget_reg;
        highest_next = highest_reg;
        running_next = running_reg;
        slot_next    = slot_reg;
        bitpos_next  = bitpos_reg;
        in_slot_next = in_slot_reg;
        shift_next   = shift_eff;
        left_next    = left_reg;
        pcount_next  = pcount_reg;
        over_next    = over_reg;
        pending_next = 1'b0;
        st_we        = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                dmx_pkg::CFG_BURST_PERIOD: period_next = cfg_data;
                dmx_pkg::CFG_BURST_BUDGET: budget_next = cfg_data;
                default: ;
            endcase
        end

        if (accept)
        begin
            case (op)
                dmx_pkg::OP_TICK:
                begin
                    pcount_next = wrap ? '0 : pc_inc;
                    left_next   = left_open;
                    over_next   = over_open;
                    if (want)
                    begin
                        if (fits)
                        begin
                            left_next = left_open - cost;
                            if (store_zero)
                            begin
                                shift_next = '0;
                            end
                            else
                            begin
                                pending_next = 1'b1;
                            end
                        end
                        else
                        begin
                            over_next = 1'b1;
                        end
                    end
                    if (emit_in_slot)
                    begin
                        in_slot_next = 1'b1;
                        bitpos_next  = pos_inc;
                        if (pos_inc >= slot_len)
                        begin
                            in_slot_next = 1'b0;
                            bitpos_next  = '0;
                            // Close the frame after the highest channel.
                            if (slot_inc > {1'b0, highest_reg})
                            begin
                                slot_next = '0;
                                over_next = 1'b1;
                            end
                            else
                            begin
                                slot_next = slot_inc[CH_W-1:0];
                            end
                        end
                    end
                end
                dmx_pkg::OP_WRITE:
                begin
                    running_next = 1'b1;
                    if (channel != '0 && channel <= NCH)
                    begin
                        st_we = 1'b1;
                        if (channel > highest_reg)
                        begin
                            highest_next = channel;
                        end
                    end
                end
                dmx_pkg::OP_SET_HIGHEST:
                begin
                    if (channel == '0)
                    begin
                        running_next = 1'b0;
                        highest_next = '0;
                        over_next    = 1'b1;
                    end
                    else
                    begin
                        running_next = 1'b1;
                        highest_next = (channel > NCH) ? NCH : channel;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg  <= dmx_pkg::PERIOD_RST;
            budget_reg  <= dmx_pkg::BUDGET_RST;
            highest_reg <= dmx_pkg::HIGHEST_RST;
            running_reg <= 1'b0;
            slot_reg    <= '0;
            bitpos_reg  <= '0;
            in_slot_reg <= 1'b0;
            shift_reg   <= '0;
            left_reg    <= '0;
            pcount_reg  <= '0;
            over_reg    <= 1'b1;
            pending_reg <= 1'b0;
        end
        else
        begin
            period_reg  <= period_next;
            budget_reg  <= budget_next;
            highest_reg <= highest_next;
            running_reg <= running_next;
            slot_reg    <= slot_next;
            bitpos_reg  <= bitpos_next;
            in_slot_reg <= in_slot_next;
            shift_reg   <= shift_next;
            left_reg    <= left_next;
            pcount_reg  <= pcount_next;
            over_reg    <= over_next;
            pending_reg <= pending_next;
        end
    end

    assign status.load_pending = pending_reg;
    assign status.in_slot      = in_slot_reg;

endmodule

[design/dmx512_frame_transmitter_unit.sv]
// Top level of the DMX512 frame transmitter: handshakes, store, result register.
// Depends on dmx_pkg, dmx_ram, dmx_clr, dmx_core and assert_macros.svh.
//
// One item per clock: a bit-period tick, a channel level write or a set of the
// highest channel. Every accepted item yields one result (line level, slot
// active, slot number) in the result register on the next cycle; the input side
// keeps accepting while that result waits, and stalls only while the store is
// being cleared or when the result register is full and out_stall holds it. The
// 512-entry channel store is a RAM; after reset a clearing sweep writes zero to
// it one entry per cycle, so in_stall stays high until all NUM_CHANNELS entries
// are cleared, while configuration writes are still taken. A channel byte is
// fetched from the store on the tick that starts its slot and is latched in the
// next cycle, before the first data bit goes out. Burst timing, budgets and slot
// sequencing all live in dmx_core.
`include "assert_macros.svh"

module dmx512_frame_transmitter_unit #(
    parameter int NUM_CHANNELS = dmx_pkg::NUM_CHANNELS_DEF,
    parameter int BREAK_BITS   = dmx_pkg::BREAK_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                operation,
    input  logic [dmx_pkg::CH_W-1:0]  channel,
    input  logic [dmx_pkg::VAL_W-1:0] value,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      line_level,
    output logic                      slot_active,
    output logic [dmx_pkg::CH_W-1:0]  slot_number,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [dmx_pkg::CFG_W-1:0] cfg_data
);

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic                      accept;
    logic                      clr_busy;
    logic [AW-1:0]             clr_addr;
    logic                      core_we;
    logic [AW-1:0]             core_waddr;
    logic [dmx_pkg::VAL_W-1:0] core_wdata;
    logic [AW-1:0]             st_raddr;
    logic [dmx_pkg::VAL_W-1:0] st_rdata;
    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [dmx_pkg::VAL_W-1:0] ram_wdata;
    dmx_pkg::result_t          core_result;
    dmx_pkg::core_status_t     core_status;

    logic                      out_valid_reg, out_valid_next;
    dmx_pkg::result_t          result_reg;

    // Hold the input while the store is being cleared or a result is blocked.
    assign in_stall = clr_busy || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;

    dmx_clr #(
        .DEPTH (NUM_CHANNELS)
    ) u_clr (
        .clk   (clk),
        .rst_n (rst_n),
        .busy  (clr_busy),
        .addr  (clr_addr)
    );

    // The sweep owns the write port while busy; no item is accepted then.
    assign ram_we    = clr_busy || core_we;
    assign ram_waddr = clr_busy ? clr_addr : core_waddr;
    assign ram_wdata = clr_busy ? '0 : core_wdata;

    dmx_ram #(
        .WIDTH (dmx_pkg::VAL_W),
        .DEPTH (NUM_CHANNELS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    dmx_core #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .BREAK_BITS   (BREAK_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .operation (operation),
        .channel   (channel),
        .value     (value),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .st_we     (core_we),
        .st_waddr  (core_waddr),
        .st_wdata  (core_wdata),
        .st_raddr  (st_raddr),
        .st_rdata  (st_rdata),
        .result    (core_result),
        .status    (core_status)
    );

    // Result register: load on accept, drain when the consumer takes the item.
    always_comb
    begin
        if (accept)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= core_result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign line_level  = result_reg.line_level;
    assign slot_active = result_reg.slot_active;
    assign slot_number = result_reg.slot_number;

    `DMX_ASSERT_IMPLIES(a_no_accept_in_clear, clr_busy, in_stall, "item taken in store clear")
    `DMX_ASSERT_IMPLIES(a_fetch_in_slot, core_status.load_pending, core_status.in_slot, "stray fetch")
    `DMX_ASSERT_IMPLIES(a_low_in_slot, out_valid && !line_level, slot_active, "low outside slot")
    `DMX_ASSERT_NEXT(a_accept_gives_result, accept, out_valid, "accepted item produced no result")

endmodule
